// ===== hw/rtl/u2c437_pkg.sv =====
// ----------------------------------------------------------------------------
// u2c437_pkg
// Types and constants shared by the UTF-8 to codepage-437 decoder: the result
// record and the multibyte sequence lookup.
// ----------------------------------------------------------------------------
package u2c437_pkg;

  // Lead byte class boundaries
  localparam logic [7:0] LeadInvalid = 8'h7F;
  localparam logic [7:0] LeadTwo     = 8'hC2;
  localparam logic [7:0] LeadThree   = 8'hE0;
  localparam logic [7:0] LeadFour    = 8'hF0;
  localparam logic [7:0] Unmapped    = 8'hFF;
  localparam logic [7:0] Terminator  = 8'h00;

  localparam int unsigned TableSize = 129;
  localparam int unsigned TableBase = 127;

  // One result record as it travels to the output stream
  typedef struct packed {
    logic [15:0] byte_count;
    logic        truncated;
    logic        end_of_string;
    logic [7:0]  out_byte;
  } res_t;

  // Sequences {b0, b1, b2}; b2 of zero marks a two-byte sequence
  localparam logic [23:0] SeqTable [TableSize] = '{
    24'hE28C82, 24'hC38700, 24'hC3BC00, 24'hC3A900, 24'hC3A200,
    24'hC3A400, 24'hC3A000, 24'hC3A500, 24'hC3A700, 24'hC3AA00,
    24'hC3AB00, 24'hC3A800, 24'hC3AF00, 24'hC3AE00, 24'hC3AC00,
    24'hC38400, 24'hC38500, 24'hC38900, 24'hC3A600, 24'hC38600,
    24'hC3B400, 24'hC3B600, 24'hC3B200, 24'hC3BB00, 24'hC3B900,
    24'hC3BF00, 24'hC39600, 24'hC39C00, 24'hC2A200, 24'hC2A300,
    24'hC2A500, 24'hE282A7, 24'hC69200, 24'hC3A100, 24'hC3AD00,
    24'hC3B300, 24'hC3BA00, 24'hC3B100, 24'hC39100, 24'hC2AA00,
    24'hC2BA00, 24'hC2BF00, 24'hE28C90, 24'hC2AC00, 24'hC2BD00,
    24'hC2BC00, 24'hC2A100, 24'hC2AB00, 24'hC2BB00, 24'hE29691,
    24'hE29692, 24'hE29693, 24'hE29482, 24'hE294A4,
    24'hE295A1, 24'hE295A2, 24'hE29596, 24'hE29595,
    24'hE295A3, 24'hE29591, 24'hE29597, 24'hE2959D,
    24'hE2959C, 24'hE2959B, 24'hE29490, 24'hE29494,
    24'hE294B4, 24'hE294AC, 24'hE2949C, 24'hE29480,
    24'hE294BC, 24'hE2959E, 24'hE2959F, 24'hE2959A,
    24'hE29594, 24'hE295A9, 24'hE295A6, 24'hE295A0,
    24'hE29590, 24'hE295AC, 24'hE295A7, 24'hE295A8,
    24'hE295A4, 24'hE295A5, 24'hE29599, 24'hE29598,
    24'hE29592, 24'hE29593, 24'hE295AB, 24'hE295AA,
    24'hE29498, 24'hE2948C, 24'hE29688, 24'hE29684,
    24'hE2968C, 24'hE29690, 24'hE29680, 24'hCEB100,
    24'hC39F00, 24'hCE9300, 24'hCF8000, 24'hCEA300, 24'hCF8300,
    24'hC2B500, 24'hCF8400, 24'hCEA600, 24'hCE9800, 24'hCEA900,
    24'hCEB400, 24'hE2889E, 24'hCF8600, 24'hCEB500,
    24'hE288A9, 24'hE289A1, 24'hC2B100, 24'hE289A5,
    24'hE289A4, 24'hE28CA0, 24'hE28CA1, 24'hC3B700,
    24'hE28988, 24'hC2B000, 24'hE28899, 24'hC2B700,
    24'hE2889A, 24'hE281BF, 24'hC2B200, 24'hE296A0,
    24'hC2A000
  };

  // Parallel compare against every table entry; the lowest match wins
  function automatic logic [7:0] seq_lookup(input logic [23:0] key);
    logic [7:0] code;
    code = Unmapped;
    for (int n = TableSize - 1; n >= 0; n--) begin
      if (SeqTable[n] == key) begin
        code = 8'(TableBase + n);
      end
    end
    return code;
  endfunction

endpackage

// ===== hw/rtl/utf8_to_cp437_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_cp437_decoder
// Converts a UTF-8 byte stream into codepage-437 bytes with terminator
// handling, an optional per-string output limit and a running byte count.
// ----------------------------------------------------------------------------
// Results are registered in the output queue for the master side.
//   Throughput: one input byte per cycle; a zero byte that closes a partial
//   sequence yields two results unless the limit is hit, and the four-entry
//   queue absorbs them; input stalls only while it holds three or more.
// Reset: rst_ni clears decoder state, the output limit (unlimited) and the
//   output queue; no clearing pass.
module utf8_to_cp437_decoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration: out_limit
  input  logic                     cfg_we_i,
  input  logic [15:0]              cfg_wdata_i,
  // input stream
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [7:0]               s_axis_tdata_i,   // [7:0] in_byte
  // output stream
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [23:0]              m_axis_tdata_o,   // [7:0] out_byte, [23:8] byte_count
  output logic                     m_axis_tlast_o,   // end_of_string
  output logic                     m_axis_tuser_o    // truncated
);
  import u2c437_pkg::*;

  localparam int unsigned CmpWidth = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  // Decoder state
  logic [15:0]            limit_q;
  logic [1:0]             pend_q, pend_d;
  logic [7:0]             lead_q, lead_d;
  logic [7:0]             sec_q, sec_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   halt_q, halt_d;

  // Output queue
  res_t                   queue_q [QDepth];
  logic [QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]         fill_q;

  logic                   in_xfer, out_xfer;
  logic [7:0]             b;
  logic [COUNT_WIDTH-1:0] nx1, nx2;
  logic [CmpWidth-1:0]    nx1_ext, nx2_ext;
  logic                   forced;
  logic [23:0]            key;
  logic [7:0]             match_code;
  logic [1:0]             n_push;
  res_t                   r0, r1;
  logic [7:0]             value;
  logic                   done;

  assign b        = s_axis_tdata_i;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // Saturating counts for the first and a following output byte
  assign nx1     = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign nx2     = (nx1 == '1) ? nx1 : nx1 + 1'b1;
  assign nx1_ext = CmpWidth'(nx1);
  assign nx2_ext = CmpWidth'(nx2);
  assign forced  = (limit_q != '0) && (nx1_ext == CmpWidth'(limit_q));

  // Sequence lookup key from the collected bytes
  assign key = (lead_q >= LeadThree) ? {lead_q, sec_q, b} : {lead_q, b, Terminator};
  assign match_code = seq_lookup(key);

  // Decode one byte into zero, one or two results
  always_comb begin
    pend_d = pend_q;
    lead_d = lead_q;
    sec_d  = sec_q;
    cnt_d  = cnt_q;
    halt_d = halt_q;
    n_push = 2'd0;
    value  = Unmapped;
    done   = 1'b0;
    r0     = '{byte_count: nx1_ext[15:0], truncated: 1'b0, end_of_string: 1'b0,
               out_byte: Unmapped};
    r1     = '{byte_count: nx2_ext[15:0], truncated: 1'b0, end_of_string: 1'b1,
               out_byte: Terminator};
    if (in_xfer) begin
      if (halt_q) begin
        if (b == Terminator) begin
          halt_d = 1'b0;
        end
      end else if (b == Terminator) begin
        pend_d = 2'd0;
        cnt_d  = '0;
        if (pend_q != 2'd0) begin
          if (forced) begin
            r0.out_byte      = Terminator;
            r0.end_of_string = 1'b1;
            r0.truncated     = 1'b1;
            n_push           = 2'd1;
          end else begin
            n_push = 2'd2;
          end
        end else begin
          r0.out_byte      = Terminator;
          r0.end_of_string = 1'b1;
          n_push           = 2'd1;
        end
      end else if (pend_q != 2'd0 || b < LeadTwo) begin
        if (pend_q != 2'd0) begin
          pend_d = pend_q - 2'd1;
          if (lead_q >= LeadFour) begin
            done = (pend_q == 2'd1);
          end else if (lead_q >= LeadThree && pend_q == 2'd2) begin
            sec_d = b;
          end else begin
            value = match_code;
            done  = 1'b1;
          end
        end else begin
          value = (b < LeadInvalid) ? b : Unmapped;
          done  = 1'b1;
        end
        // Emit, or force the terminator when the limit is hit
        if (done) begin
          n_push = 2'd1;
          if (forced) begin
            r0.out_byte      = Terminator;
            r0.end_of_string = 1'b1;
            r0.truncated     = 1'b1;
            cnt_d            = '0;
            halt_d           = 1'b1;
            pend_d           = 2'd0;
          end else begin
            r0.out_byte = value;
            cnt_d       = nx1;
          end
        end
      end else begin
        lead_d = b;
        sec_d  = 8'h00;
        pend_d = (b < LeadThree) ? 2'd1 : (b < LeadFour) ? 2'd2 : 2'd3;
      end
    end
  end

  // Hold decoder state and the output limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      pend_q  <= '0;
      lead_q  <= '0;
      sec_q   <= '0;
      cnt_q   <= '0;
      halt_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      pend_q <= pend_d;
      lead_q <= lead_d;
      sec_q  <= sec_d;
      cnt_q  <= cnt_d;
      halt_q <= halt_d;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fill_q <= fill_q + (QPtrW + 1)'(n_push) - (QPtrW + 1)'(out_xfer);
    end
  end

  // Queue entries: write up to two results per cycle
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= r0;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_q + 1'b1] <= r1;
    end
  end

  // Accept input while two queue slots are free
  assign s_axis_tready_o = (fill_q <= (QPtrW + 1)'(QDepth - 2));
  assign m_axis_tvalid_o = (fill_q != '0);
  assign m_axis_tdata_o  = {queue_q[rd_ptr_q].byte_count, queue_q[rd_ptr_q].out_byte};
  assign m_axis_tlast_o  = queue_q[rd_ptr_q].end_of_string;
  assign m_axis_tuser_o  = queue_q[rd_ptr_q].truncated;

endmodule

// ===== hw/rtl/u2c437_checker.sv =====
// ----------------------------------------------------------------------------
// u2c437_checker
// Port-level checks on the decoder's output stream, bound to the top level.
// ----------------------------------------------------------------------------
module u2c437_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o
);

  // No result shows while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  // A forced terminator is a terminator with a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'h00)
    else $error("truncation flag without terminator");

  // Every terminator carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[7:0] == 8'h00)
    else $error("terminator with nonzero byte");

  // The count includes the current byte, so it is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[23:8] != 16'h0000)
    else $error("byte count of zero on a result");

endmodule

bind utf8_to_cp437_decoder u2c437_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
